// ===== rtl/core/lrat_pkg.sv =====
// Shared types, constants and arithmetic helpers for the luminance recolor
// accent tint block. No dependencies.
`default_nettype none

package lrat_pkg;

   localparam int ChanWidth   = 8;
   localparam int ColorWidth  = 3 * ChanWidth;
   localparam int CsrIdxWidth = 2;
   localparam int NumChan     = 3;

   localparam logic [ChanWidth-1:0]  FullScale    = 8'd255;
   localparam logic [ChanWidth-1:0]  SatThreshold = 8'd30;
   localparam logic [ColorWidth-1:0] FgReset      = 24'h000000;
   localparam logic [ColorWidth-1:0] BgReset      = 24'hFFFFFF;
   localparam logic [ColorWidth-1:0] AccentReset  = 24'h000000;

   // sum / 3 == (sum * 43691) >> 17 for any sum below 2**16
   localparam logic [15:0] ThirdMul   = 16'd43691;
   localparam int          ThirdShift = 17;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_FG_COLOR      = 2'd0,
      CSR_BG_COLOR      = 2'd1,
      CSR_ACCENT_COLOR  = 2'd2,
      CSR_ACCENT_ENABLE = 2'd3
   } csr_index_type;

   typedef logic [ChanWidth-1:0] chan_type;

   // x / 255 for x <= 255*255
   function automatic chan_type div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return t[15:8];
   endfunction

   // one restoring division step: {quotient bit, new remainder}
   function automatic logic [8:0] div_step(input chan_type rem, input logic nbit,
                                          input chan_type dvs);
      logic [8:0] sh;
      logic [8:0] diff;
      sh   = {rem, nbit};
      diff = sh - {1'b0, dvs};
      if (sh >= {1'b0, dvs}) begin
         return {1'b1, diff[7:0]};
      end else begin
         return {1'b0, sh[7:0]};
      end
   endfunction

   // a * wa + b * wb, never above 255*255 when wa + wb == 255
   function automatic logic [15:0] mix(input chan_type a, input chan_type wa,
                                      input chan_type b, input chan_type wb);
      logic [15:0] pa;
      logic [15:0] pb;
      pa = {8'd0, a} * {8'd0, wa};
      pb = {8'd0, b} * {8'd0, wb};
      return pa + pb;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/luminance_recolor_accent_tint.sv =====
// Pipeline: 8 stages; rsp_valid rises when an accepted req transaction reaches the stage 8 register.
// Throughput: one pixel per cycle; the whole 8-stage pipeline holds while
// rsp_valid is high and rsp_stall is asserted.
// Saturation divide: restoring divider, 2 quotient bits in each of stages 3..6.
// Reset (synchronous, active high) empties the pipeline and loads the
// color registers with their defaults (fg black, bg white, accent off).
`default_nettype none

module luminance_recolor_accent_tint (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [lrat_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire logic [lrat_pkg::ColorWidth-1:0]  csr_wr_data,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [lrat_pkg::ChanWidth-1:0]   req_in_red,
   input  wire logic [lrat_pkg::ChanWidth-1:0]   req_in_green,
   input  wire logic [lrat_pkg::ChanWidth-1:0]   req_in_blue,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [lrat_pkg::ChanWidth-1:0]        rsp_out_red,
   output logic [lrat_pkg::ChanWidth-1:0]        rsp_out_green,
   output logic [lrat_pkg::ChanWidth-1:0]        rsp_out_blue
);

   localparam int Stages = 8;

   // configuration
   logic [lrat_pkg::ColorWidth-1:0] fg_color_ff;
   logic [lrat_pkg::ColorWidth-1:0] bg_color_ff;
   logic [lrat_pkg::ColorWidth-1:0] accent_color_ff;
   logic                            accent_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_color_ff      <= lrat_pkg::FgReset;
         bg_color_ff      <= lrat_pkg::BgReset;
         accent_color_ff  <= lrat_pkg::AccentReset;
         accent_enable_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (lrat_pkg::csr_index_type'(csr_index))
            lrat_pkg::CSR_FG_COLOR:      fg_color_ff      <= csr_wr_data;
            lrat_pkg::CSR_BG_COLOR:      bg_color_ff      <= csr_wr_data;
            lrat_pkg::CSR_ACCENT_COLOR:  accent_color_ff  <= csr_wr_data;
            lrat_pkg::CSR_ACCENT_ENABLE: accent_enable_ff <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic [Stages-1:0] valid_ff;
   logic [Stages-1:0] valid_in;
   logic              advance;

   assign advance   = !(valid_ff[Stages-1] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = valid_ff[Stages-1];
   assign valid_in  = {valid_ff[Stages-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // stage registers
   logic [9:0]               s1_sum_ff, s1_sum_in;
   lrat_pkg::chan_type       s1_max_ff, s1_max_in;
   lrat_pkg::chan_type       s1_min_ff, s1_min_in;

   lrat_pkg::chan_type       s2_lum_ff, s2_lum_in;
   logic [15:0]              s2_num_ff, s2_num_in;
   lrat_pkg::chan_type       s2_max_ff;

   logic [15:0]              s3_mix_ff [lrat_pkg::NumChan];
   logic [15:0]              s3_mix_in [lrat_pkg::NumChan];
   logic [15:0]              s3_num_ff;
   lrat_pkg::chan_type       s3_rem_ff, s3_rem_in;
   lrat_pkg::chan_type       s3_quo_ff, s3_quo_in;
   lrat_pkg::chan_type       s3_max_ff;

   lrat_pkg::chan_type       s4_res_ff [lrat_pkg::NumChan];
   lrat_pkg::chan_type       s4_res_in [lrat_pkg::NumChan];
   logic [15:0]              s4_num_ff;
   lrat_pkg::chan_type       s4_rem_ff, s4_rem_in;
   lrat_pkg::chan_type       s4_quo_ff, s4_quo_in;
   lrat_pkg::chan_type       s4_max_ff;

   lrat_pkg::chan_type       s5_res_ff [lrat_pkg::NumChan];
   logic [15:0]              s5_num_ff;
   lrat_pkg::chan_type       s5_rem_ff, s5_rem_in;
   lrat_pkg::chan_type       s5_quo_ff, s5_quo_in;
   lrat_pkg::chan_type       s5_max_ff;

   lrat_pkg::chan_type       s6_res_ff [lrat_pkg::NumChan];
   lrat_pkg::chan_type       s6_sat_ff, s6_sat_in;
   lrat_pkg::chan_type       s6_max_ff;

   logic [15:0]              s7_mix_ff [lrat_pkg::NumChan];
   logic [15:0]              s7_mix_in [lrat_pkg::NumChan];
   lrat_pkg::chan_type       s7_res_ff [lrat_pkg::NumChan];
   logic                     s7_tint_ff, s7_tint_in;

   lrat_pkg::chan_type       s8_out_ff [lrat_pkg::NumChan];
   lrat_pkg::chan_type       s8_out_in [lrat_pkg::NumChan];

   // stage 1: channel sum, max, min
   always_comb begin
      lrat_pkg::chan_type mx;
      lrat_pkg::chan_type mn;
      mx = req_in_red;
      mn = req_in_red;
      if (req_in_green > mx) mx = req_in_green;
      if (req_in_blue  > mx) mx = req_in_blue;
      if (req_in_green < mn) mn = req_in_green;
      if (req_in_blue  < mn) mn = req_in_blue;
      s1_max_in = mx;
      s1_min_in = mn;
      s1_sum_in = {2'd0, req_in_red} + {2'd0, req_in_green} + {2'd0, req_in_blue};
   end

   // stage 2: luminance = sum / 3, divide numerator = chroma * 255
   always_comb begin
      logic [25:0]        prod;
      lrat_pkg::chan_type chroma;
      prod      = {16'd0, s1_sum_ff} * {10'd0, lrat_pkg::ThirdMul};
      s2_lum_in = prod[lrat_pkg::ThirdShift +: lrat_pkg::ChanWidth];
      chroma    = s1_max_ff - s1_min_ff;
      s2_num_in = {chroma, 8'd0} - {8'd0, chroma};
   end

   // stage 3: luminance blend, quotient bits 7..6
   always_comb begin
      logic [8:0] st_a;
      logic [8:0] st_b;
      for (int c = 0; c < lrat_pkg::NumChan; c++) begin
         s3_mix_in[c] = lrat_pkg::mix(fg_color_ff[8*(2-c) +: 8],
                                      lrat_pkg::FullScale - s2_lum_ff,
                                      bg_color_ff[8*(2-c) +: 8], s2_lum_ff);
      end
      st_a      = lrat_pkg::div_step(s2_num_ff[15:8], s2_num_ff[7], s2_max_ff);
      st_b      = lrat_pkg::div_step(st_a[7:0], s2_num_ff[6], s2_max_ff);
      s3_rem_in = st_b[7:0];
      s3_quo_in = {6'd0, st_a[8], st_b[8]};
   end

   // stage 4: / 255, quotient bits 5..4
   always_comb begin
      logic [8:0] st_a;
      logic [8:0] st_b;
      for (int c = 0; c < lrat_pkg::NumChan; c++) begin
         s4_res_in[c] = lrat_pkg::div255(s3_mix_ff[c]);
      end
      st_a      = lrat_pkg::div_step(s3_rem_ff, s3_num_ff[5], s3_max_ff);
      st_b      = lrat_pkg::div_step(st_a[7:0], s3_num_ff[4], s3_max_ff);
      s4_rem_in = st_b[7:0];
      s4_quo_in = {s3_quo_ff[5:0], st_a[8], st_b[8]};
   end

   // stage 5: quotient bits 3..2
   always_comb begin
      logic [8:0] st_a;
      logic [8:0] st_b;
      st_a      = lrat_pkg::div_step(s4_rem_ff, s4_num_ff[3], s4_max_ff);
      st_b      = lrat_pkg::div_step(st_a[7:0], s4_num_ff[2], s4_max_ff);
      s5_rem_in = st_b[7:0];
      s5_quo_in = {s4_quo_ff[5:0], st_a[8], st_b[8]};
   end

   // stage 6: quotient bits 1..0
   always_comb begin
      logic [8:0] st_a;
      logic [8:0] st_b;
      st_a      = lrat_pkg::div_step(s5_rem_ff, s5_num_ff[1], s5_max_ff);
      st_b      = lrat_pkg::div_step(st_a[7:0], s5_num_ff[0], s5_max_ff);
      s6_sat_in = {s5_quo_ff[5:0], st_a[8], st_b[8]};
   end

   // stage 7: accent blend; black pixel (max 0) never tints
   always_comb begin
      s7_tint_in = accent_enable_ff && (s6_max_ff != '0) &&
                   (s6_sat_ff > lrat_pkg::SatThreshold);
      for (int c = 0; c < lrat_pkg::NumChan; c++) begin
         s7_mix_in[c] = lrat_pkg::mix(s6_res_ff[c], lrat_pkg::FullScale - s6_sat_ff,
                                      accent_color_ff[8*(2-c) +: 8], s6_sat_ff);
      end
   end

   // stage 8: output select
   always_comb begin
      for (int c = 0; c < lrat_pkg::NumChan; c++) begin
         s8_out_in[c] = s7_tint_ff ? lrat_pkg::div255(s7_mix_ff[c]) : s7_res_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sum_ff  <= s1_sum_in;
         s1_max_ff  <= s1_max_in;
         s1_min_ff  <= s1_min_in;

         s2_lum_ff  <= s2_lum_in;
         s2_num_ff  <= s2_num_in;
         s2_max_ff  <= s1_max_ff;

         s3_mix_ff  <= s3_mix_in;
         s3_num_ff  <= s2_num_ff;
         s3_rem_ff  <= s3_rem_in;
         s3_quo_ff  <= s3_quo_in;
         s3_max_ff  <= s2_max_ff;

         s4_res_ff  <= s4_res_in;
         s4_num_ff  <= s3_num_ff;
         s4_rem_ff  <= s4_rem_in;
         s4_quo_ff  <= s4_quo_in;
         s4_max_ff  <= s3_max_ff;

         s5_res_ff  <= s4_res_ff;
         s5_num_ff  <= s4_num_ff;
         s5_rem_ff  <= s5_rem_in;
         s5_quo_ff  <= s5_quo_in;
         s5_max_ff  <= s4_max_ff;

         s6_res_ff  <= s5_res_ff;
         s6_sat_ff  <= s6_sat_in;
         s6_max_ff  <= s5_max_ff;

         s7_mix_ff  <= s7_mix_in;
         s7_res_ff  <= s6_res_ff;
         s7_tint_ff <= s7_tint_in;

         s8_out_ff  <= s8_out_in;
      end
   end

   assign rsp_out_red   = s8_out_ff[0];
   assign rsp_out_green = s8_out_ff[1];
   assign rsp_out_blue  = s8_out_ff[2];

endmodule

`default_nettype wire

// ===== rtl/core/lrat_checker.sv =====
// Port-level assertions for luminance_recolor_accent_tint, bound to the top level.
// Depends on lrat_pkg for field widths.
`default_nettype none

module lrat_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_stall,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [lrat_pkg::ChanWidth-1:0] rsp_out_red,
   input wire logic [lrat_pkg::ChanWidth-1:0] rsp_out_green,
   input wire logic [lrat_pkg::ChanWidth-1:0] rsp_out_blue
);

   // a held rsp transaction keeps its pixel
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_red) &&
                                    $stable(rsp_out_green) && $stable(rsp_out_blue)))
      else $error("stalled rsp transaction changed");

   // input side stalls exactly when the output is blocked
   assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("req_stall does not track output backpressure");

   // reset empties the pipeline
   assert property (@(posedge clock) ($past(reset) && !reset) |-> !rsp_valid)
      else $error("rsp_valid after reset");

   // handshake signals are always known out of reset
   assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_valid, req_stall, rsp_valid, rsp_stall}))
      else $error("unknown handshake signal");

   // an offered rsp transaction carries a known pixel
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown({rsp_out_red, rsp_out_green, rsp_out_blue}))
      else $error("unknown pixel on rsp transaction");

endmodule

bind luminance_recolor_accent_tint lrat_checker u_lrat_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_red   (rsp_out_red),
   .rsp_out_green (rsp_out_green),
   .rsp_out_blue  (rsp_out_blue)
);

`default_nettype wire
